### rtl/core/gcr_pkg.sv
// gcr_pkg: shared constants, widths and controller/datapath types
// for the grid ray caster. no dependencies.

package gcr_pkg;

  // map and number formats
  localparam int MAP_SIDE  = 8;
  localparam int FRAC_W    = 16;
  localparam int COORD_W   = 24;
  localparam int DIR_W     = 18;
  localparam int POS_W     = 26;
  localparam int REL_W     = 23;
  localparam int SQ_W      = 2 * REL_W;
  localparam int OFF_W     = FRAC_W + 2;
  localparam int PROD_W    = 2 * OFF_W;
  localparam int MAG_W     = PROD_W - 2;
  localparam int QUO_W     = FRAC_W + 1;
  localparam int REM_W     = DIR_W + 1;
  localparam int ROW_W     = 3;
  localparam int BIT_W     = 6;
  localparam int STEP_CAP  = 64;
  localparam int STEP_W    = 7;
  localparam int DCNT_W    = 5;
  localparam int MAP_W     = 64;
  localparam int MAXD_W    = 4;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_MAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic sq;
    logic chk;
    logic sel;
    logic div_step;
    logic upd;
    logic hit_chk;
    logic out_load;
  } gcr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic stop;
    logic div_last;
    logic hit;
    logic out_free;
  } gcr_stat_t;

endpackage

### rtl/core/gcr_if.sv
// gcr_if: ray input and result channel interfaces, valid/ready handshake.
// depends on gcr_pkg.

interface gcr_ray_if;
  import gcr_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [COORD_W-1:0]   origin_x;
  logic signed [COORD_W-1:0]   origin_y;
  logic signed [DIR_W-1:0]     dir_x;
  logic signed [DIR_W-1:0]     dir_y;
  modport source (output valid, origin_x, origin_y, dir_x, dir_y, input ready);
  modport sink   (input valid, origin_x, origin_y, dir_x, dir_y, output ready);
endinterface

interface gcr_res_if;
  import gcr_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [COORD_W-1:0]   end_x;
  logic signed [COORD_W-1:0]   end_y;
  logic                        hit;
  logic [ROW_W-1:0]            hit_row;
  logic [ROW_W-1:0]            hit_col;
  modport source (output valid, end_x, end_y, hit, hit_row, hit_col, input ready);
  modport sink   (input valid, end_x, end_y, hit, hit_row, hit_col, output ready);
endinterface

### rtl/core/gcr_ctrl.sv
// gcr_ctrl: state machine that sequences one ray walk step by step.
// depends on gcr_pkg.

module gcr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gcr_pkg::gcr_stat_t stat,
  output gcr_pkg::gcr_cmd_t  cmd
);
  import gcr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_SEL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_HIT  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = stat.stop ? S_OUT : S_SEL;
      end
      S_SEL: begin
        cmd.sel   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_HIT;
      end
      S_HIT: begin
        cmd.hit_chk = 1'b1;
        state_nxt   = stat.hit ? S_OUT : S_SQ;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### rtl/core/gcr_dp.sv
// gcr_dp: ray walk datapath: position, distance check, crossing select,
// shared shift-subtract divider, map lookup and result register. uses gcr_pkg.

module gcr_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gcr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcr_pkg::MAP_W-1:0]          cfg_wdata,
  input  logic signed [gcr_pkg::COORD_W-1:0] in_origin_x,
  input  logic signed [gcr_pkg::COORD_W-1:0] in_origin_y,
  input  logic signed [gcr_pkg::DIR_W-1:0]   in_dir_x,
  input  logic signed [gcr_pkg::DIR_W-1:0]   in_dir_y,
  input  gcr_pkg::gcr_cmd_t                  cmd,
  output gcr_pkg::gcr_stat_t                 stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [gcr_pkg::COORD_W-1:0] out_end_x,
  output logic signed [gcr_pkg::COORD_W-1:0] out_end_y,
  output logic                               out_hit,
  output logic [gcr_pkg::ROW_W-1:0]          out_hit_row,
  output logic [gcr_pkg::ROW_W-1:0]          out_hit_col
);
  import gcr_pkg::*;

  localparam logic signed [POS_W-1:0] SIDE_Q = POS_W'(MAP_SIDE * (1 << FRAC_W));
  localparam logic signed [POS_W-1:0] C_MAX  = POS_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [POS_W-1:0] C_MIN  = -POS_W'(1 << (COORD_W - 1));

  // configuration registers
  logic [MAP_W-1:0]  map_r;
  logic [MAXD_W-1:0] maxd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r  <= '0;
      maxd_r <= MAXD_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELL_MAP: map_r  <= cfg_wdata;
        CFG_MAX_DIST: maxd_r <= cfg_wdata[MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  // ray state
  logic signed [COORD_W-1:0] ox_r, oy_r;
  logic signed [DIR_W-1:0]   dx_r, dy_r;
  logic signed [POS_W-1:0]   px_r, py_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r;
  logic signed [OFF_W-1:0]   offx_r, offy_r;
  logic [PROD_W-2:0]         pa_r, pb_r;
  logic                      horiz_r, neg_r;
  logic [MAG_W-1:0]          lo_r;
  logic [DIR_W-1:0]          dvs_r;
  logic [REM_W-1:0]          rem_r;
  logic [QUO_W-1:0]          quo_r;
  logic [DCNT_W-1:0]         dcnt_r;
  logic [STEP_W-1:0]         n_r;
  logic                      hit_r;
  logic [ROW_W-1:0]          row_r, col_r;

  // abs of directions
  logic [DIR_W-1:0] adx, ady;
  assign adx = dx_r[DIR_W-1] ? DIR_W'(-dx_r) : DIR_W'(dx_r);
  assign ady = dy_r[DIR_W-1] ? DIR_W'(-dy_r) : DIR_W'(dy_r);

  // offsets to the next grid lines in the direction of travel
  logic signed [OFF_W-1:0] offx, offy;
  logic [QUO_W-1:0]        ex, ey;
  always_comb begin
    if (!dx_r[DIR_W-1])
      offx = (px_r[FRAC_W-1:0] == '0) ? '0 : OFF_W'(17'h10000 - {1'b0, px_r[FRAC_W-1:0]});
    else
      offx = -OFF_W'({2'b0, px_r[FRAC_W-1:0]});
    if (!dy_r[DIR_W-1])
      offy = (py_r[FRAC_W-1:0] == '0) ? '0 : OFF_W'(17'h10000 - {1'b0, py_r[FRAC_W-1:0]});
    else
      offy = -OFF_W'({2'b0, py_r[FRAC_W-1:0]});
  end
  assign ex = offx_r[OFF_W-1] ? QUO_W'(-offx_r) : QUO_W'(offx_r);
  assign ey = offy_r[OFF_W-1] ? QUO_W'(-offy_r) : QUO_W'(offy_r);

  // distance from origin
  logic signed [POS_W-1:0] rx_full, ry_full;
  logic signed [REL_W-1:0] rx, ry;
  assign rx_full = px_r - POS_W'(ox_r);
  assign ry_full = py_r - POS_W'(oy_r);
  assign rx = rx_full[REL_W-1:0];
  assign ry = ry_full[REL_W-1:0];

  logic [2*MAXD_W-1:0] msq;
  logic [SQ_W:0]       dsum, lim;
  assign msq  = maxd_r * maxd_r;
  assign dsum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign lim  = {(SQ_W + 1 - 2 * MAXD_W - 32)'(0), msq, 32'b0};
  assign stat.stop = (dsum >= lim) || (n_r == STEP_W'(STEP_CAP));

  // crossing select and numerator
  logic                     horiz;
  logic signed [PROD_W-1:0] prod;
  assign horiz = pa_r < pb_r;
  assign prod  = horiz ? offy_r * dx_r : offx_r * dy_r;

  logic [PROD_W-1:0] prod_mag;
  assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

  // divider step
  logic [REM_W:0]   trial;
  logic             qbit;
  assign trial = {rem_r, lo_r[QUO_W-1]};
  assign qbit  = trial >= {2'b0, dvs_r};
  assign stat.div_last = (dcnt_r == DCNT_W'(QUO_W - 1));

  // signed quotient and next point
  logic signed [POS_W-1:0] qs, nx, ny;
  always_comb begin
    qs = neg_r ? -POS_W'({1'b0, quo_r}) : POS_W'({1'b0, quo_r});
    if (horiz_r) begin
      ny = py_r + POS_W'(offy_r);
      nx = px_r + qs;
    end else begin
      nx = px_r + POS_W'(offx_r);
      ny = py_r + qs;
    end
  end

  // map lookup
  logic              in_map, cell_hit;
  logic [ROW_W-1:0]  prow, pcol;
  logic [BIT_W-1:0]  bidx;
  assign in_map = (px_r > 0) && (py_r > 0) && (px_r < SIDE_Q) && (py_r < SIDE_Q);
  assign prow   = py_r[FRAC_W+ROW_W-1:FRAC_W];
  assign pcol   = px_r[FRAC_W+ROW_W-1:FRAC_W];
  assign bidx   = BIT_W'(int'(prow) * MAP_SIDE + int'(pcol));
  assign cell_hit = in_map && map_r[bidx];
  assign stat.hit = cell_hit;

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ox_r   <= in_origin_x;
      oy_r   <= in_origin_y;
      dx_r   <= (in_dir_x == '0) ? DIR_W'(1) : in_dir_x;
      dy_r   <= (in_dir_y == '0) ? DIR_W'(1) : in_dir_y;
      px_r   <= POS_W'(in_origin_x);
      py_r   <= POS_W'(in_origin_y);
      n_r    <= '0;
      hit_r  <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
    end
    if (cmd.sq) begin
      sqx_r  <= rx * rx;
      sqy_r  <= ry * ry;
      offx_r <= offx;
      offy_r <= offy;
    end
    // horizontal crossing is nearer when ey*|dx| < ex*|dy|
    if (cmd.chk) begin
      pa_r <= ey * adx;
      pb_r <= ex * ady;
    end
    if (cmd.sel) begin
      horiz_r <= horiz;
      neg_r   <= prod[PROD_W-1] ^ (horiz ? dy_r[DIR_W-1] : dx_r[DIR_W-1]);
      dvs_r   <= horiz ? ady : adx;
      rem_r   <= REM_W'(prod_mag[MAG_W-1:QUO_W]);
      lo_r    <= prod_mag[MAG_W-1:0];
      quo_r   <= '0;
      dcnt_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= qbit ? REM_W'(trial - {2'b0, dvs_r}) : trial[REM_W-1:0];
      quo_r  <= {quo_r[QUO_W-2:0], qbit};
      lo_r   <= {lo_r[MAG_W-2:0], 1'b0};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.upd) begin
      px_r <= dx_r[DIR_W-1] ? nx - POS_W'(1) : nx + POS_W'(1);
      py_r <= dy_r[DIR_W-1] ? ny - POS_W'(1) : ny + POS_W'(1);
      n_r  <= n_r + 1'b1;
    end
    if (cmd.hit_chk && cell_hit) begin
      hit_r <= 1'b1;
      row_r <= prow;
      col_r <= pcol;
    end
  end

  // result register
  logic out_valid_r;
  logic signed [COORD_W-1:0] ex_out_r, ey_out_r;
  logic                      hit_out_r;
  logic [ROW_W-1:0]          row_out_r, col_out_r;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [POS_W-1:0] v);
    if (v > C_MAX)      sat = C_MAX[COORD_W-1:0];
    else if (v < C_MIN) sat = C_MIN[COORD_W-1:0];
    else                sat = v[COORD_W-1:0];
  endfunction

  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ex_out_r  <= sat(px_r);
      ey_out_r  <= sat(py_r);
      hit_out_r <= hit_r;
      row_out_r <= row_r;
      col_out_r <= col_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_end_x   = ex_out_r;
  assign out_end_y   = ey_out_r;
  assign out_hit     = hit_out_r;
  assign out_hit_row = row_out_r;
  assign out_hit_col = col_out_r;

endmodule

### rtl/core/grid_ray_caster.sv
// grid_ray_caster: one ray per transaction walked across the 8x8 wall map.
// each grid crossing runs through the bit-serial divider, and the walk ends
// when the reach limit is met or when a wall is hit;
// one ray at a time, 64 crossings per ray at most.
// the result register lets the next ray start while a result waits.
// reset (synchronous, active low): map cleared, reach limit 10, channels idle.

module grid_ray_caster (
  input  logic                          clk,
  input  logic                          rst_n,
  gcr_ray_if.sink                       in_ch,
  gcr_res_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [gcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcr_pkg::MAP_W-1:0]     cfg_wdata
);
  import gcr_pkg::*;

  gcr_cmd_t  cmd;
  gcr_stat_t stat;

  // sequencer
  gcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  gcr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_origin_x (in_ch.origin_x),
    .in_origin_y (in_ch.origin_y),
    .in_dir_x    (in_ch.dir_x),
    .in_dir_y    (in_ch.dir_y),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_end_x   (out_ch.end_x),
    .out_end_y   (out_ch.end_y),
    .out_hit     (out_ch.hit),
    .out_hit_row (out_ch.hit_row),
    .out_hit_col (out_ch.hit_col)
  );

endmodule
